// ===== hw/rtl/nbs_pkg.sv =====
// Shared constants, register codes and configuration type for the noise brush pipeline.
package nbs_pkg;

  localparam int PosWidth      = 32;
  localparam int PosFracBits   = 8;
  localparam int RadiusWidth   = 24;
  localparam int StrengthWidth = 16;
  localparam int ReachWidth    = RadiusWidth + 1;
  localparam int SquareWidth   = 2 * ReachWidth;

  // Register indexes on the configuration port
  localparam logic [2:0] RegCenterX  = 3'd0;
  localparam logic [2:0] RegCenterY  = 3'd1;
  localparam logic [2:0] RegCenterZ  = 3'd2;
  localparam logic [2:0] RegRadius   = 3'd3;
  localparam logic [2:0] RegFalloff  = 3'd4;
  localparam logic [2:0] RegStrength = 3'd5;
  localparam logic [2:0] RegDigMode  = 3'd6;

  // Reset values
  localparam logic [RadiusWidth-1:0]   RadiusReset   = 24'd25600;
  localparam logic [StrengthWidth-1:0] StrengthReset = 16'd256;

  // Noise cell: 50 units = 25 << (PosFracBits + 1)
  localparam int CellShift   = PosFracBits + 1;
  localparam int CellDivisor = 25;
  localparam int CellBiasQ   = 1 << 18;
  localparam int CellBias    = CellDivisor * CellBiasQ;
  localparam int CellRecipShift = 29;
  localparam logic [24:0] CellRecip = 25'((64'd1 << CellRecipShift) / CellDivisor + 1);

  // Hash constants
  localparam logic [31:0] HashMul1 = 32'h7feb352d;
  localparam logic [31:0] HashMul2 = 32'h846ca68b;
  localparam logic [23:0] NoiseMax = 24'hFFFFFF;

  // Unit value of t and weight in Q0.16
  localparam logic [16:0] UnitQ16 = 17'h10000;

  // Iterative unit layout
  localparam int SqrtSteps         = ReachWidth;
  localparam int SqrtStepsPerStage = 5;
  localparam int SqrtStages        = SqrtSteps / SqrtStepsPerStage;
  localparam int DivSteps          = 16;
  localparam int DivStepsPerStage  = 4;
  localparam int DivStages         = DivSteps / DivStepsPerStage;

  // Stage counts of each path
  localparam int DistLatency  = 3 + SqrtStages + DivStages + 3;
  localparam int NoiseLatency = 12;
  localparam int NoiseAlign   = DistLatency - NoiseLatency;
  localparam int PipeLatency  = DistLatency + 4;

  typedef struct packed {
    logic signed [PosWidth-1:0] center_x;
    logic signed [PosWidth-1:0] center_y;
    logic signed [PosWidth-1:0] center_z;
    logic [RadiusWidth-1:0]     radius;
    logic [RadiusWidth-1:0]     falloff_width;
    logic [StrengthWidth-1:0]   strength;
    logic                       dig_mode;
  } cfg_t;

endpackage

// ===== hw/rtl/noise_brush_sdf_displacement.sv =====
// Top level of the noise sphere brush: registers, pipeline control and output scaling.
//
// Usage: one voxel position (pos_x, pos_y, pos_z) is taken per beat on the input
// channel (in_valid/in_ready) and one result (displacement, in_reach, saturated)
// leaves per beat on the output channel (out_valid/out_ready), in input order.
// Brush registers are written on the cfg channel (cfg_index, cfg_data), which is
// always ready; write them only while no beat is in flight.
// Throughput is one beat per cycle while the output is not stalled: the square
// root (5 stages, 5 bits each), the radius divide (4 stages, 4 bits each) and
// the hash multiplies are fully pipelined. The whole pipeline advances together;
// when the output holds a beat that the receiver does not take, every stage
// holds and in_ready drops in the same cycle, so nothing is lost or repeated.
// Bubbles keep their place.
// Reset clears all valid bits and loads the register defaults: centre 0,
// radius 100.0, falloff 0, strength 1.0, raise mode.
module noise_brush_sdf_displacement (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [nbs_pkg::PosWidth-1:0] pos_x,
  input  logic signed [nbs_pkg::PosWidth-1:0] pos_y,
  input  logic signed [nbs_pkg::PosWidth-1:0] pos_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [31:0]                  displacement,
  output logic                                in_reach,
  output logic                                saturated,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [2:0]                          cfg_index,
  input  logic [31:0]                         cfg_data
);

  localparam int Lat = nbs_pkg::PipeLatency;

  nbs_pkg::cfg_t cfg;

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x      <= '0;
      cfg.center_y      <= '0;
      cfg.center_z      <= '0;
      cfg.radius        <= nbs_pkg::RadiusReset;
      cfg.falloff_width <= '0;
      cfg.strength      <= nbs_pkg::StrengthReset;
      cfg.dig_mode      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        nbs_pkg::RegCenterX:  cfg.center_x      <= cfg_data;
        nbs_pkg::RegCenterY:  cfg.center_y      <= cfg_data;
        nbs_pkg::RegCenterZ:  cfg.center_z      <= cfg_data;
        nbs_pkg::RegRadius:   cfg.radius        <= cfg_data[23:0];
        nbs_pkg::RegFalloff:  cfg.falloff_width <= cfg_data[23:0];
        nbs_pkg::RegStrength: cfg.strength      <= cfg_data[15:0];
        nbs_pkg::RegDigMode:  cfg.dig_mode      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline advance and valid bits
  logic           en;
  logic [Lat:1]   vld;
  assign en        = !vld[Lat] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[Lat];
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Lat-1:1], in_valid};
    end
  end

  logic [16:0] weight;
  logic        reach_ok;
  logic [16:0] noise_mag;
  logic        noise_neg;

  nbs_dist u_dist (
    .clk      (clk),
    .en       (en),
    .cfg      (cfg),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .pos_z    (pos_z),
    .weight   (weight),
    .in_reach (reach_ok)
  );

  nbs_noise u_noise (
    .clk       (clk),
    .en        (en),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .noise_mag (noise_mag),
    .noise_neg (noise_neg)
  );

  // Weighted noise, rounded to Q0.16
  logic [34:0] fw_round;
  logic [16:0] g;
  logic        g_neg, g_ok;
  assign fw_round = 35'(noise_mag) * 35'(weight) + 35'(32768);
  always_ff @(posedge clk) begin
    if (en) begin
      g     <= 17'(fw_round >> 16);
      g_neg <= noise_neg ^ cfg.dig_mode;
      g_ok  <= reach_ok;
    end
  end

  // Scale by strength
  logic [32:0] gs;
  logic        gs_neg, gs_ok;
  always_ff @(posedge clk) begin
    if (en) begin
      gs     <= 33'(g) * 33'(cfg.strength);
      gs_neg <= g_neg;
      gs_ok  <= g_ok;
    end
  end

  // Scale by radius
  logic [56:0] pr;
  logic        pr_neg, pr_ok;
  always_ff @(posedge clk) begin
    if (en) begin
      pr     <= 57'(gs) * 57'(cfg.radius);
      pr_neg <= gs_neg;
      pr_ok  <= gs_ok;
    end
  end

  // Round, clip, apply sign and drop out-of-reach results
  logic [57:0] pr_round;
  logic [31:0] mag;
  logic        clip;
  logic [31:0] mag_c;
  assign pr_round = 58'(pr) + 58'(64'd1 << 25);
  assign mag      = pr_round[57:26];
  assign clip     = pr_neg ? (mag > 32'h80000000) : (mag > 32'h7FFFFFFF);
  assign mag_c    = clip ? (pr_neg ? 32'h80000000 : 32'h7FFFFFFF) : mag;
  always_ff @(posedge clk) begin
    if (en) begin
      if (pr_ok) begin
        displacement <= pr_neg ? (~mag_c + 32'd1) : mag_c;
        in_reach     <= 1'b1;
        saturated    <= clip;
      end else begin
        displacement <= '0;
        in_reach     <= 1'b0;
        saturated    <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_zero_out_of_reach: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_reach |-> displacement == 32'sd0 && !saturated)
    else $error("out-of-reach beat carries a nonzero result");

  a_clip_at_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> displacement == 32'sh7FFFFFFF || displacement == 32'sh80000000)
    else $error("saturated beat not at a range limit");

  a_stall_only_on_block: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input held off without an output stall");
`endif

endmodule

// ===== hw/rtl/nbs_dist.sv =====
// Distance path: reach test, pipelined square root, divide by radius and smoothstep weight.
module nbs_dist (
  input  logic                                clk,
  input  logic                                en,
  input  nbs_pkg::cfg_t                       cfg,
  input  logic signed [nbs_pkg::PosWidth-1:0] pos_x,
  input  logic signed [nbs_pkg::PosWidth-1:0] pos_y,
  input  logic signed [nbs_pkg::PosWidth-1:0] pos_z,
  output logic [16:0]                         weight,
  output logic                                in_reach
);

  localparam int SqS = nbs_pkg::SqrtStages;
  localparam int DvS = nbs_pkg::DivStages;

  function automatic logic [nbs_pkg::PosWidth:0] abs_diff(
    input logic signed [nbs_pkg::PosWidth-1:0] p,
    input logic signed [nbs_pkg::PosWidth-1:0] c
  );
    logic signed [nbs_pkg::PosWidth:0] d;
    d = (nbs_pkg::PosWidth+1)'(p) - (nbs_pkg::PosWidth+1)'(c);
    return d[nbs_pkg::PosWidth] ? (nbs_pkg::PosWidth+1)'(-d) : (nbs_pkg::PosWidth+1)'(d);
  endfunction

  // Stage 1: axis distances
  logic [nbs_pkg::PosWidth:0] s1_ax, s1_ay, s1_az;
  always_ff @(posedge clk) begin
    if (en) begin
      s1_ax <= abs_diff(pos_x, cfg.center_x);
      s1_ay <= abs_diff(pos_y, cfg.center_y);
      s1_az <= abs_diff(pos_z, cfg.center_z);
    end
  end

  // Stage 2: per-axis reach test and squares
  logic [nbs_pkg::ReachWidth-1:0]  reach;
  logic [nbs_pkg::SquareWidth-1:0] s2_sqx, s2_sqy, s2_sqz, s2_rsq;
  logic                            s2_axis_ok;
  assign reach = nbs_pkg::ReachWidth'(cfg.radius) + nbs_pkg::ReachWidth'(cfg.falloff_width);
  always_ff @(posedge clk) begin
    if (en) begin
      s2_axis_ok <= (s1_ax <= (nbs_pkg::PosWidth+1)'(reach)) &&
                    (s1_ay <= (nbs_pkg::PosWidth+1)'(reach)) &&
                    (s1_az <= (nbs_pkg::PosWidth+1)'(reach));
      s2_sqx <= s1_ax[24:0] * s1_ax[24:0];
      s2_sqy <= s1_ay[24:0] * s1_ay[24:0];
      s2_sqz <= s1_az[24:0] * s1_az[24:0];
      s2_rsq <= reach * reach;
    end
  end

  // Stage 3: sum of squares and sphere test
  logic [51:0] sum_sq;
  logic [49:0] s3_val;
  logic        s3_ok;
  assign sum_sq = 52'(s2_sqx) + 52'(s2_sqy) + 52'(s2_sqz);
  always_ff @(posedge clk) begin
    if (en) begin
      s3_val <= sum_sq[49:0];
      s3_ok  <= s2_axis_ok && (sum_sq <= 52'(s2_rsq));
    end
  end

  // Square root: two radicand bits per step, several steps per stage
  logic [27:0] sq_rem  [1:SqS];
  logic [24:0] sq_root [1:SqS];
  logic [49:0] sq_val  [1:SqS];
  logic        sq_ok   [1:SqS];

  for (genvar s = 0; s < SqS; s++) begin : g_sqrt
    logic [27:0] rem_i;
    logic [24:0] root_i;
    logic [49:0] val_i;
    logic        ok_i;
    logic [27:0] rem_c;
    logic [24:0] root_c;
    logic [49:0] val_c;
    if (s == 0) begin : g_src
      assign rem_i  = '0;
      assign root_i = '0;
      assign val_i  = s3_val;
      assign ok_i   = s3_ok;
    end else begin : g_src
      assign rem_i  = sq_rem[s];
      assign root_i = sq_root[s];
      assign val_i  = sq_val[s];
      assign ok_i   = sq_ok[s];
    end
    always_comb begin
      logic [27:0] rem_sh;
      logic [27:0] trial;
      rem_c  = rem_i;
      root_c = root_i;
      val_c  = val_i;
      for (int i = 0; i < nbs_pkg::SqrtStepsPerStage; i++) begin
        rem_sh = {rem_c[25:0], val_c[49:48]};
        trial  = {1'b0, root_c, 2'b01};
        if (rem_sh >= trial) begin
          rem_c  = rem_sh - trial;
          root_c = {root_c[23:0], 1'b1};
        end else begin
          rem_c  = rem_sh;
          root_c = {root_c[23:0], 1'b0};
        end
        val_c = {val_c[47:0], 2'b00};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem[s+1]  <= rem_c;
        sq_root[s+1] <= root_c;
        sq_val[s+1]  <= val_c;
        sq_ok[s+1]   <= ok_i;
      end
    end
  end

  // Division by radius: one quotient bit per step
  logic [23:0] dv_rem [1:DvS];
  logic [15:0] dv_q   [1:DvS];
  logic        dv_ge  [1:DvS];
  logic        dv_ok  [1:DvS];

  for (genvar s = 0; s < DvS; s++) begin : g_div
    logic [23:0] rem_i;
    logic [15:0] q_i;
    logic        ge_i;
    logic        ok_i;
    logic [23:0] rem_c;
    logic [15:0] q_c;
    if (s == 0) begin : g_src
      assign rem_i = sq_root[SqS][23:0];
      assign q_i   = '0;
      assign ge_i  = sq_root[SqS] >= 25'(cfg.radius);
      assign ok_i  = sq_ok[SqS];
    end else begin : g_src
      assign rem_i = dv_rem[s];
      assign q_i   = dv_q[s];
      assign ge_i  = dv_ge[s];
      assign ok_i  = dv_ok[s];
    end
    always_comb begin
      logic [24:0] rem_sh;
      rem_c = rem_i;
      q_c   = q_i;
      for (int i = 0; i < nbs_pkg::DivStepsPerStage; i++) begin
        rem_sh = {rem_c, 1'b0};
        if (rem_sh >= 25'(cfg.radius)) begin
          rem_c = 24'(rem_sh - 25'(cfg.radius));
          q_c   = {q_c[14:0], 1'b1};
        end else begin
          rem_c = rem_sh[23:0];
          q_c   = {q_c[14:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem[s+1] <= rem_c;
        dv_q[s+1]   <= q_c;
        dv_ge[s+1]  <= ge_i;
        dv_ok[s+1]  <= ok_i;
      end
    end
  end

  // Smoothstep: t squared and the cubic factor
  logic [16:0] t_q16;
  logic [33:0] sm_tt;
  logic [17:0] sm_k;
  logic        sm1_ok;
  assign t_q16 = dv_ge[DvS] ? nbs_pkg::UnitQ16 : {1'b0, dv_q[DvS]};
  always_ff @(posedge clk) begin
    if (en) begin
      sm_tt  <= t_q16 * t_q16;
      sm_k   <= 18'd196608 - {t_q16, 1'b0};
      sm1_ok <= dv_ok[DvS];
    end
  end

  logic [51:0] sm_prod;
  logic        sm2_ok;
  always_ff @(posedge clk) begin
    if (en) begin
      sm_prod <= 52'(sm_tt) * 52'(sm_k);
      sm2_ok  <= sm1_ok;
    end
  end

  // Round the cubic and turn it into the weight
  logic [51:0] sm_round;
  assign sm_round = sm_prod + 52'(64'd1 << 31);
  always_ff @(posedge clk) begin
    if (en) begin
      weight   <= nbs_pkg::UnitQ16 - 17'(sm_round[51:32]);
      in_reach <= sm2_ok;
    end
  end

endmodule

// ===== hw/rtl/nbs_noise.sv =====
// Noise path: cell index, three rounds of the integer hash and the Q0.16 noise magnitude.
module nbs_noise (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [nbs_pkg::PosWidth-1:0] pos_x,
  input  logic signed [nbs_pkg::PosWidth-1:0] pos_y,
  input  logic signed [nbs_pkg::PosWidth-1:0] pos_z,
  output logic [16:0]                         noise_mag,
  output logic                                noise_neg
);

  localparam int QW = nbs_pkg::PosWidth - nbs_pkg::CellShift;

  function automatic logic [23:0] cell_biased(input logic signed [nbs_pkg::PosWidth-1:0] p);
    logic signed [QW-1:0] q;
    q = QW'(p >>> nbs_pkg::CellShift);
    return 24'(q) + 24'(nbs_pkg::CellBias);
  endfunction

  function automatic logic [31:0] fold16(input logic [31:0] x);
    return x ^ (x >> 16);
  endfunction

  function automatic logic [31:0] fold15(input logic [31:0] x);
    return x ^ (x >> 15);
  endfunction

  // Stage 1: floor by the power-of-two part, bias to positive
  logic [23:0] s1_ux, s1_uy, s1_uz;
  always_ff @(posedge clk) begin
    if (en) begin
      s1_ux <= cell_biased(pos_x);
      s1_uy <= cell_biased(pos_y);
      s1_uz <= cell_biased(pos_z);
    end
  end

  // Stage 2: reciprocal multiply for the divide by 25
  logic [48:0] s2_px, s2_py, s2_pz;
  always_ff @(posedge clk) begin
    if (en) begin
      s2_px <= 49'(s1_ux) * 49'(nbs_pkg::CellRecip);
      s2_py <= 49'(s1_uy) * 49'(nbs_pkg::CellRecip);
      s2_pz <= 49'(s1_uz) * 49'(nbs_pkg::CellRecip);
    end
  end

  // Stage 3: remove the bias to get signed cell indexes
  logic [31:0] s3_cx, s3_cy, s3_cz;
  always_ff @(posedge clk) begin
    if (en) begin
      s3_cx <= 32'(s2_px[48:nbs_pkg::CellRecipShift]) - 32'(nbs_pkg::CellBiasQ);
      s3_cy <= 32'(s2_py[48:nbs_pkg::CellRecipShift]) - 32'(nbs_pkg::CellBiasQ);
      s3_cz <= 32'(s2_pz[48:nbs_pkg::CellRecipShift]) - 32'(nbs_pkg::CellBiasQ);
    end
  end

  // Stages 4 to 9: one hash multiply per stage
  logic [31:0] s4_a, s4_cy, s4_cz;
  logic [31:0] s5_b, s5_cy, s5_cz;
  logic [31:0] s6_a, s6_cz;
  logic [31:0] s7_b, s7_cz;
  logic [31:0] s8_a;
  logic [31:0] s9_b;
  always_ff @(posedge clk) begin
    if (en) begin
      s4_a  <= fold16(s3_cx) * nbs_pkg::HashMul1;
      s4_cy <= s3_cy;
      s4_cz <= s3_cz;
      s5_b  <= fold15(s4_a) * nbs_pkg::HashMul2;
      s5_cy <= s4_cy;
      s5_cz <= s4_cz;
      s6_a  <= fold16(fold16(s5_b) ^ s5_cy) * nbs_pkg::HashMul1;
      s6_cz <= s5_cz;
      s7_b  <= fold15(s6_a) * nbs_pkg::HashMul2;
      s7_cz <= s6_cz;
      s8_a  <= fold16(fold16(s7_b) ^ s7_cz) * nbs_pkg::HashMul1;
      s9_b  <= fold15(s8_a) * nbs_pkg::HashMul2;
    end
  end

  // Stage 10: fold the hash, centre the low 24 bits
  logic [31:0] hash;
  logic [24:0] two_n;
  logic        below_mid;
  logic [24:0] s10_a;
  logic        s10_neg;
  assign hash      = fold16(s9_b);
  assign two_n     = {hash[23:0], 1'b0};
  assign below_mid = two_n < 25'(nbs_pkg::NoiseMax);
  always_ff @(posedge clk) begin
    if (en) begin
      s10_a   <= below_mid ? 25'(nbs_pkg::NoiseMax) - two_n : two_n - 25'(nbs_pkg::NoiseMax);
      s10_neg <= below_mid;
    end
  end

  // Stage 11: scale by 65536 and split for the divide by 2^24-1
  logic [40:0] scaled;
  logic [16:0] s11_q;
  logic [24:0] s11_r;
  logic        s11_neg;
  assign scaled = {1'b0, s10_a[23:0], 16'h0000} + 41'h7FFFFF;
  always_ff @(posedge clk) begin
    if (en) begin
      s11_q   <= scaled[40:24];
      s11_r   <= 25'(scaled[23:0]) + 25'(scaled[40:24]);
      s11_neg <= s10_neg;
    end
  end

  // Stage 12: one correction step
  logic [16:0] s12_f;
  logic        s12_neg;
  always_ff @(posedge clk) begin
    if (en) begin
      s12_f   <= s11_q + 17'(s11_r >= 25'(nbs_pkg::NoiseMax));
      s12_neg <= s11_neg;
    end
  end

  // Align with the distance path
  logic [16:0] al_f   [1:nbs_pkg::NoiseAlign];
  logic        al_neg [1:nbs_pkg::NoiseAlign];
  for (genvar s = 0; s < nbs_pkg::NoiseAlign; s++) begin : g_align
    logic [16:0] f_i;
    logic        neg_i;
    if (s == 0) begin : g_src
      assign f_i   = s12_f;
      assign neg_i = s12_neg;
    end else begin : g_src
      assign f_i   = al_f[s];
      assign neg_i = al_neg[s];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        al_f[s+1]   <= f_i;
        al_neg[s+1] <= neg_i;
      end
    end
  end

  assign noise_mag = al_f[nbs_pkg::NoiseAlign];
  assign noise_neg = al_neg[nbs_pkg::NoiseAlign];

endmodule
